[hdl/mfmse_pkg.sv]
// ----------------------------------------------------------------------------
// mfmse_pkg
// Shared types, constants and the CORDIC angle table for the fitness evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mfmse_pkg;

  localparam logic [16:0] MAX_SAMPLES  = 17'd65536;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [4:0]  CORDIC_LAST  = 5'd19;
  localparam logic [62:0] SUM_MAX      = {63{1'b1}};
  localparam logic [33:0] FX_CLAMP     = 34'h2_0000_0000;
  localparam logic [5:0]  DIV_LAST     = 6'd62;
  localparam int          FIFO_DEPTH   = 4;
  localparam int          FIFO_AW      = 2;

  // configuration register indexes
  localparam logic [1:0] REG_COEF_A = 2'd0;
  localparam logic [1:0] REG_COEF_B = 2'd1;
  localparam logic [1:0] REG_COEF_C = 2'd2;

  typedef struct packed {
    logic [63:0] sq;
    logic        last;
  } sq_item_t;

  typedef enum logic [3:0] {
    F_IDLE, F_SQR, F_FOLD, F_PHASE, F_CORD, F_COS, F_BC, F_INNER,
    F_AMUL, F_FX, F_RES, F_SQ, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_ACC, B_DIV, B_DONE
  } back_state_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/model_fit_mean_square_error.sv]
// ----------------------------------------------------------------------------
// model_fit_mean_square_error
// Mean squared residual of a*(x^2 - b*cos(c*pi*x)) against (x, y) samples.
// ----------------------------------------------------------------------------
// Channel   Ports                                          Direction
// in        in_push/in_full, sample_x, sample_y, last     request in
// out       out_pop/out_empty, mean_error, count, ovf      request out
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data       register write
//
// The front takes one sample at a time through the 20-step CORDIC loop
// and the chain of steps around it; in_full stays high until it is queued.
// A last sample starts a restoring division in the back, which runs
// alongside the front's next samples; a four-entry queue sits between them.
// Reset is synchronous; no clearing pass. The result register holds a
// finished request while the back keeps accumulating the next set.
// ----------------------------------------------------------------------------
`default_nettype none

module model_fit_mean_square_error (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [31:0] in_sample_x,
  input  wire logic signed [31:0] in_sample_y,
  input  wire logic               in_last_sample,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [62:0]             out_mean_error,
  output logic [16:0]             out_sample_count,
  output logic                    out_overflowed,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r;
  mfmse_pkg::sq_item_t f_item, b_item;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= 32'sd65536;
      coef_b_r <= '0;
      coef_c_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfmse_pkg::REG_COEF_A: coef_a_r <= cfg_data;
        mfmse_pkg::REG_COEF_B: coef_b_r <= cfg_data;
        mfmse_pkg::REG_COEF_C: coef_c_r <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  mfmse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef_a         (coef_a_r),
    .coef_b         (coef_b_r),
    .coef_c         (coef_c_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_last_sample (in_last_sample),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_item         (f_item)
  );

  mfmse_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (b_item),
    .empty   (q_empty)
  );

  mfmse_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (b_item),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_mean_error   (out_mean_error),
    .out_sample_count (out_sample_count),
    .out_overflowed   (out_overflowed)
  );

endmodule

`default_nettype wire

[hdl/mfmse_front.sv]
// ----------------------------------------------------------------------------
// mfmse_front
// Takes one sample and works out its squared residual over a sequence of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmse_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [31:0]   coef_a,
  input  wire logic signed [31:0]   coef_b,
  input  wire logic signed [31:0]   coef_c,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic signed [31:0]   in_sample_x,
  input  wire logic signed [31:0]   in_sample_y,
  input  wire logic                 in_last_sample,
  output logic                      q_push,
  input  wire logic                 q_full,
  output mfmse_pkg::sq_item_t       q_item
);

  mfmse_pkg::front_state_t state_r, state_nxt;

  logic signed [31:0] x_r, y_r;
  logic               last_r;
  logic [46:0]        x2_r;
  logic [32:0]        t_r;
  logic [31:0]        tf_r;
  logic               neg_r;
  logic signed [32:0] z_r;
  logic signed [33:0] cx_r, cy_r;
  logic [4:0]         step_r;
  logic [19:0]        csm_r;
  logic               csneg_r;
  logic [35:0]        bcm_r;
  logic               bcneg_r;
  logic [47:0]        im_r;
  logic               fxneg_r;
  logic [55:0]        ph_r, pl_r;
  logic [33:0]        fm_r;
  logic [31:0]        rm_r;
  logic [63:0]        sq_r;

  logic signed [63:0] xx, cxp;
  logic [33:0]        t1, t2;
  logic [63:0]        zp;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  logic signed [19:0] cxs;
  logic signed [20:0] cs;
  logic [31:0]        bm, am;
  logic [51:0]        bp;
  logic signed [48:0] bc, inner;
  logic [56:0]        fsum;
  logic [33:0]        fm_raw;
  logic signed [34:0] fx;
  logic signed [35:0] r;
  logic signed [31:0] rs;

  always_comb begin
    xx     = x_r * x_r;
    cxp    = coef_c * x_r;
    // fold phase into [0, 1/2] half-turns
    t1     = ({1'b0, t_r} > 34'h1_0000_0000) ? (34'h2_0000_0000 - {1'b0, t_r})
                                              : {1'b0, t_r};
    t2     = (t1 > 34'h0_8000_0000) ? (34'h1_0000_0000 - t1) : t1;
    zp     = tf_r * mfmse_pkg::PI_Q30;
    xs     = cx_r >>> step_r;
    ys     = cy_r >>> step_r;
    at     = {3'b000, mfmse_pkg::atan_q30(step_r)};
    cxs    = cx_r[33:14];
    cs     = neg_r ? -{cxs[19], cxs} : {cxs[19], cxs};
    bm     = coef_b[31] ? 32'(-coef_b) : 32'(coef_b);
    am     = coef_a[31] ? 32'(-coef_a) : 32'(coef_a);
    bp     = bm * csm_r;
    bc     = bcneg_r ? -$signed({13'd0, bcm_r}) : $signed({13'd0, bcm_r});
    inner  = $signed({2'b00, x2_r}) - bc;
    fsum   = {ph_r[32:0], 24'd0} + {1'b0, pl_r};
    fm_raw = (ph_r >= 56'd33554432) ? mfmse_pkg::FX_CLAMP
           : ((fsum[56:16] > {7'd0, mfmse_pkg::FX_CLAMP}) ? mfmse_pkg::FX_CLAMP
                                                          : fsum[49:16]);
    fx     = fxneg_r ? -$signed({1'b0, fm_r}) : $signed({1'b0, fm_r});
    r      = $signed({{4{y_r[31]}}, y_r}) - $signed({fx[34], fx});
    priority if (r > 36'sd2147483647) begin
      rs = 32'sh7FFF_FFFF;
    end else if (r < -36'sd2147483648) begin
      rs = 32'sh8000_0000;
    end else begin
      rs = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfmse_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_full   = 1'b1;
    q_push    = 1'b0;
    unique case (state_r)
      mfmse_pkg::F_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          state_nxt = mfmse_pkg::F_SQR;
        end
      end
      mfmse_pkg::F_SQR:   state_nxt = mfmse_pkg::F_FOLD;
      mfmse_pkg::F_FOLD:  state_nxt = mfmse_pkg::F_PHASE;
      mfmse_pkg::F_PHASE: state_nxt = mfmse_pkg::F_CORD;
      mfmse_pkg::F_CORD: begin
        if (step_r == mfmse_pkg::CORDIC_LAST) begin
          state_nxt = mfmse_pkg::F_COS;
        end
      end
      mfmse_pkg::F_COS:   state_nxt = mfmse_pkg::F_BC;
      mfmse_pkg::F_BC:    state_nxt = mfmse_pkg::F_INNER;
      mfmse_pkg::F_INNER: state_nxt = mfmse_pkg::F_AMUL;
      mfmse_pkg::F_AMUL:  state_nxt = mfmse_pkg::F_FX;
      mfmse_pkg::F_FX:    state_nxt = mfmse_pkg::F_RES;
      mfmse_pkg::F_RES:   state_nxt = mfmse_pkg::F_SQ;
      mfmse_pkg::F_SQ:    state_nxt = mfmse_pkg::F_PUSH;
      mfmse_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = mfmse_pkg::F_IDLE;
        end
      end
      default: state_nxt = mfmse_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      mfmse_pkg::F_IDLE: begin
        x_r    <= in_sample_x;
        y_r    <= in_sample_y;
        last_r <= in_last_sample;
      end
      mfmse_pkg::F_SQR: begin
        x2_r <= xx[62:16];
        t_r  <= cxp[32:0];
      end
      mfmse_pkg::F_FOLD: begin
        tf_r  <= t2[31:0];
        neg_r <= (t1 > 34'h0_8000_0000);
      end
      mfmse_pkg::F_PHASE: begin
        z_r    <= $signed({1'b0, zp[63:32]});
        cx_r   <= mfmse_pkg::CORDIC_GAIN_Q30;
        cy_r   <= '0;
        step_r <= '0;
      end
      mfmse_pkg::F_CORD: begin
        if (!z_r[32]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          z_r  <= z_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          z_r  <= z_r + at;
        end
        step_r <= step_r + 5'd1;
      end
      mfmse_pkg::F_COS: begin
        csneg_r <= cs[20];
        csm_r   <= cs[20] ? 20'(-cs) : cs[19:0];
      end
      mfmse_pkg::F_BC: begin
        bcm_r   <= bp[51:16];
        bcneg_r <= coef_b[31] != csneg_r;
      end
      mfmse_pkg::F_INNER: begin
        im_r    <= inner[48] ? 48'(-inner) : inner[47:0];
        fxneg_r <= coef_a[31] != inner[48];
      end
      mfmse_pkg::F_AMUL: begin
        ph_r <= am * im_r[47:24];
        pl_r <= am * im_r[23:0];
      end
      mfmse_pkg::F_FX:  fm_r <= fm_raw;
      mfmse_pkg::F_RES: rm_r <= rs[31] ? 32'(-rs) : 32'(rs);
      mfmse_pkg::F_SQ:  sq_r <= rm_r * rm_r;
      mfmse_pkg::F_PUSH: ;
      default: ;
    endcase
  end

  assign q_item.sq   = sq_r;
  assign q_item.last = last_r;

endmodule

`default_nettype wire

[hdl/mfmse_fifo.sv]
// ----------------------------------------------------------------------------
// mfmse_fifo
// Short queue of squared residuals between the front and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmse_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mfmse_pkg::sq_item_t  wr_item,
  output logic                      full,
  input  wire logic                 pop,
  output mfmse_pkg::sq_item_t       rd_item,
  output logic                      empty
);

  mfmse_pkg::sq_item_t mem_r [mfmse_pkg::FIFO_DEPTH];
  logic [mfmse_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [mfmse_pkg::FIFO_AW:0]   cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == (mfmse_pkg::FIFO_AW+1)'(mfmse_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (mfmse_pkg::FIFO_AW+1)'(do_push) - (mfmse_pkg::FIFO_AW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

[hdl/mfmse_back.sv]
// ----------------------------------------------------------------------------
// mfmse_back
// Accumulates squared residuals and divides the sum by the count per data set.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmse_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mfmse_pkg::sq_item_t  q_item,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [62:0]               out_mean_error,
  output logic [16:0]               out_sample_count,
  output logic                      out_overflowed
);

  mfmse_pkg::back_state_t state_r, state_nxt;

  logic [62:0] sum_r;
  logic [16:0] cnt_r;
  logic        ovf_r;
  logic [62:0] quo_r;
  logic [16:0] rem_r, div_r;
  logic        dovf_r;
  logic [5:0]  dstep_r;
  logic        out_valid_r;
  logic [62:0] out_mean_r;
  logic [16:0] out_cnt_r;
  logic        out_ovf_r;

  logic        drop;
  logic [64:0] sum_add;
  logic        sat;
  logic [62:0] sum_new;
  logic [16:0] cnt_new;
  logic        ovf_new;
  logic [17:0] rem2;
  logic        ge;
  logic        load_out;

  always_comb begin
    drop    = (cnt_r == mfmse_pkg::MAX_SAMPLES);
    sum_add = {2'b00, sum_r} + {1'b0, q_item.sq};
    sat     = sum_add > {2'b00, mfmse_pkg::SUM_MAX};
    sum_new = drop ? sum_r : (sat ? mfmse_pkg::SUM_MAX : sum_add[62:0]);
    cnt_new = drop ? cnt_r : cnt_r + 17'd1;
    ovf_new = ovf_r || drop || sat;
    rem2    = {rem_r, quo_r[62]};
    ge      = rem2 >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfmse_pkg::B_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      mfmse_pkg::B_ACC: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.last) begin
            state_nxt = mfmse_pkg::B_DIV;
          end
        end
      end
      mfmse_pkg::B_DIV: begin
        if (dstep_r == mfmse_pkg::DIV_LAST) begin
          state_nxt = mfmse_pkg::B_DONE;
        end
      end
      mfmse_pkg::B_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = mfmse_pkg::B_ACC;
        end
      end
      default: state_nxt = mfmse_pkg::B_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_item.last) begin
          sum_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sum_r <= sum_new;
          cnt_r <= cnt_new;
          ovf_r <= ovf_new;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      quo_r   <= sum_new;
      div_r   <= cnt_new;
      dovf_r  <= ovf_new;
      rem_r   <= '0;
      dstep_r <= '0;
    end else if (state_r == mfmse_pkg::B_DIV) begin
      rem_r   <= ge ? 17'(rem2 - {1'b0, div_r}) : rem2[16:0];
      quo_r   <= {quo_r[61:0], ge};
      dstep_r <= dstep_r + 6'd1;
    end
    if (load_out) begin
      out_mean_r <= (div_r == '0) ? '0 : quo_r;
      out_cnt_r  <= div_r;
      out_ovf_r  <= dovf_r;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_mean_error   = out_mean_r;
  assign out_sample_count = out_cnt_r;
  assign out_overflowed   = out_ovf_r;

endmodule

`default_nettype wire
